// File: sv/terdt_pkg.sv
// Shared types and constants of the triangle rasterizer with depth test.
package terdt_pkg;

	localparam int SUBPIXEL_STEPS = 16;
	localparam int SCALE          = 2 * SUBPIXEL_STEPS;
	localparam int DEPTH_W        = 16;
	localparam int DN_W           = 18 + $clog2(SCALE);
	localparam int EV_W           = 22 + $clog2(SUBPIXEL_STEPS) + 1;
	localparam int ZSUM_W         = DN_W + DEPTH_W + 2;
	localparam int L_W            = 17;
	localparam int INVW_W         = 32;
	localparam int Q_W            = L_W + INVW_W;
	localparam int DEN_W          = Q_W + 2;
	localparam int NUM_W          = Q_W + 10;
	localparam int DIV_W          = 60;
	localparam int QUO_W          = 17;
	localparam int NB_W           = 5;

	localparam logic [0:0] CFG_WIDTH  = 1'b0;
	localparam logic [0:0] CFG_HEIGHT = 1'b1;

	localparam logic ACT_VERTEX = 1'b0;
	localparam logic ACT_PIXEL  = 1'b1;

	localparam logic [1:0] SLOT_LAST = 2'd2;
	localparam logic [1:0] SLOT_NONE = 2'd3;

	typedef struct packed {
		logic        action;
		logic [1:0]  vertex_slot;
		logic [8:0]  vertex_x;
		logic [8:0]  vertex_y;
		logic [15:0] vertex_depth;
		logic [31:0] vertex_inv_w;
		logic [7:0]  vertex_red;
		logic [7:0]  vertex_green;
		logic [7:0]  vertex_blue;
		logic [7:0]  pixel_x;
		logic [7:0]  pixel_y;
	} item_t;

	typedef struct packed {
		logic        triangle_culled;
		logic        covered;
		logic        depth_passed;
		logic [15:0] pixel_index;
		logic [15:0] depth;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} result_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [DIV_W-1:0]  divisor_sh;
		logic [NB_W-1:0]   nbits;
	} div_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETUP,
		ST_PIXEL,
		ST_EDGE,
		ST_ZMUL,
		ST_ZDIVS,
		ST_ZDIV,
		ST_LDIVS,
		ST_LDIV,
		ST_QMUL,
		ST_CACC,
		ST_CDIVS,
		ST_CDIV,
		ST_DONE
	} state_t;

endpackage

// File: sv/terdt_div.sv
// Restoring divider, one quotient bit per cycle.
module terdt_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  terdt_pkg::div_req_t                 req,
	output logic                                done,
	output logic [terdt_pkg::QUO_W-1:0]         quo
);

	logic [terdt_pkg::DIV_W-1:0] rem_q;
	logic [terdt_pkg::DIV_W-1:0] dsh_q;
	logic [terdt_pkg::QUO_W-1:0] quo_q;
	logic [terdt_pkg::NB_W-1:0]  cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic                        ge;

	assign ge = (rem_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= req.nbits;
		end else if (busy_q) begin
			cnt_q <= cnt_q - terdt_pkg::NB_W'(1);
			if (cnt_q == terdt_pkg::NB_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend;
			dsh_q <= req.divisor_sh;
			quo_q <= '0;
		end else if (busy_q) begin
			// subtract the shifted divisor where it fits
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[terdt_pkg::QUO_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// File: sv/terdt_zmem.sv
// Depth buffer memory with a clearing sweep after reset.
module terdt_zmem #(
	parameter int ENTRIES = 65536
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                rd_en,
	input  logic [$clog2(ENTRIES)-1:0]          rd_addr,
	output logic [terdt_pkg::DEPTH_W-1:0]       rd_data,
	input  logic                                wr_en,
	input  logic [$clog2(ENTRIES)-1:0]          wr_addr,
	input  logic [terdt_pkg::DEPTH_W-1:0]       wr_data,
	output logic                                clearing
);

	localparam int AW = $clog2(ENTRIES);

	logic [terdt_pkg::DEPTH_W-1:0] mem [ENTRIES];
	logic                          clr_q;
	logic [AW-1:0]                 clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
			if (clr_cnt_q == AW'(ENTRIES - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_cnt_q] <= '1;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign clearing = clr_q;

endmodule

// File: sv/triangle_edge_rasterizer_depth_test.sv
// Top level: triangle setup, edge test, depth test and perspective-correct colour.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------
//  item    | in        | item_valid/stall    | vertex load or pixel (item_t)
//  result  | out       | result_valid/stall  | verdict, index, depth, colour
//  cfg     | in        | cfg_valid/ready     | cfg_index, cfg_data (viewport)
//
// One item at a time. A vertex load in slot 2 runs the setup, one edge per
// cycle. A covered pixel uses the shared bit-serial divider: one depth
// quotient and, if the depth test passes, three barycentric quotients and
// three colour quotients (skipped when their weight sum is zero), one bit a
// cycle. After reset the depth buffer is swept to farthest, and no item
// transfer is taken until the sweep ends. A finished result waits in the
// output register while the next item is taken in.
module triangle_edge_rasterizer_depth_test #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  terdt_pkg::item_t     item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output terdt_pkg::result_t   result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [0:0]           cfg_index,
	input  logic [8:0]           cfg_data
);

	localparam int ENTRIES = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW      = $clog2(ENTRIES);
	localparam int IW      = (AW > 18) ? AW : 18;
	localparam int DNW     = terdt_pkg::DN_W;
	localparam int EVW     = terdt_pkg::EV_W;
	localparam int ZSW     = terdt_pkg::ZSUM_W;
	localparam int QW      = terdt_pkg::Q_W;
	localparam int DENW    = terdt_pkg::DEN_W;
	localparam int NUMW    = terdt_pkg::NUM_W;
	localparam int DIVW    = terdt_pkg::DIV_W;
	localparam int NBW     = terdt_pkg::NB_W;
	localparam int Z_BITS  = 16;
	localparam int L_BITS  = 17;
	localparam int C_BITS  = 8;

	terdt_pkg::state_t state_q, state_d;

	// configuration
	logic [8:0] vw_cfg_q, vh_cfg_q;

	// vertex stores
	logic [8:0]  vx_q    [0:2];
	logic [8:0]  vy_q    [0:2];
	logic [15:0] vz_q    [0:2];
	logic [31:0] vinvw_q [0:2];
	logic [23:0] vcol_q  [0:2];

	// triangle setup
	logic signed [9:0]  ea_q [0:2];
	logic signed [9:0]  eb_q [0:2];
	logic signed [19:0] ec_q [0:2];
	logic signed [19:0] area_q;
	logic               tri_valid_q;

	// per-pixel working registers
	logic [1:0]                cnt_q;
	logic [7:0]                px_q, py_q;
	logic [AW-1:0]             addr_q;
	logic [DNW-1:0]            dn_q;
	logic [DNW-1:0]            n_q [0:2];
	logic                      ncov_q;
	logic [ZSW-1:0]            zsum_q;
	logic [terdt_pkg::L_W-1:0] l_q [0:2];
	logic [QW-1:0]             qp_q;
	logic [DENW-1:0]           den_q;
	logic [NUMW-1:0]           num_q [0:2];
	terdt_pkg::result_t        res_q;

	// output register
	logic               out_valid_q;
	terdt_pkg::result_t out_q;

	logic item_acc, out_load, cnt_last;
	logic [1:0] cnt_step;

	terdt_pkg::div_req_t           div_req;
	logic                          div_done;
	logic [terdt_pkg::QUO_W-1:0]   div_quo;

	logic                          mem_rd_en, mem_wr_en, clearing;
	logic [terdt_pkg::DEPTH_W-1:0] mem_rd_data;

	function automatic logic [1:0] nxt(input logic [1:0] i);
		logic [1:0] r;
		case (i)
			2'd0:    r = 2'd1;
			2'd1:    r = 2'd2;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic logic [8:0] clamp_dim(input logic [8:0] v, input int maxv);
		logic [8:0] r;
		if (v == 9'd0) begin
			r = 9'd1;
		end else if (32'(v) > maxv) begin
			r = 9'(maxv);
		end else begin
			r = v;
		end
		return r;
	endfunction

	assign cnt_last = (cnt_q == 2'd2);
	assign cnt_step = cnt_last ? 2'd0 : cnt_q + 2'd1;

	// setup of one edge
	logic [1:0]         s_j, s_k;
	logic signed [9:0]  s_a, s_b;
	logic signed [19:0] s_c, area_nx;

	assign s_j     = nxt(cnt_q);
	assign s_k     = nxt(s_j);
	assign s_a     = $signed({1'b0, vy_q[s_j]}) - $signed({1'b0, vy_q[s_k]});
	assign s_b     = $signed({1'b0, vx_q[s_k]}) - $signed({1'b0, vx_q[s_j]});
	assign s_c     = 20'($signed({1'b0, vx_q[s_j]})) * 20'($signed({1'b0, vy_q[s_k]}))
	               - 20'($signed({1'b0, vx_q[s_k]})) * 20'($signed({1'b0, vy_q[s_j]}));
	assign area_nx = area_q + s_c;

	// viewport and buffer index
	logic [8:0]    vw, vh, row;
	logic          in_range;
	logic [17:0]   idx18;
	logic [IW-1:0] idx_full;
	logic [19:0]   area_mag;

	assign vw       = clamp_dim(vw_cfg_q, MAX_WIDTH);
	assign vh       = clamp_dim(vh_cfg_q, MAX_HEIGHT);
	assign in_range = (9'(px_q) < vw) && (9'(py_q) < vh);
	assign row      = vh - 9'd1 - 9'(py_q);
	assign idx18    = 18'(row) * 18'(vw) + 18'(px_q);
	assign idx_full = IW'(idx18);
	assign area_mag = 20'(-area_q);

	// edge function at the pixel centre, scaled
	logic signed [9:0]     ex, ey;
	logic signed [19:0]    e_px, e_py;
	logic signed [21:0]    e_sum;
	logic signed [EVW-1:0] e_v, e_neg;
	logic                  e_pos;

	assign ex    = $signed({1'b0, px_q, 1'b1});
	assign ey    = $signed({1'b0, py_q, 1'b1});
	assign e_px  = 20'(ea_q[cnt_q]) * 20'(ex);
	assign e_py  = 20'(eb_q[cnt_q]) * 20'(ey);
	assign e_sum = 22'(e_px) + 22'(e_py) + (22'(ec_q[cnt_q]) <<< 1);
	assign e_v   = EVW'(e_sum) * $signed(EVW'(terdt_pkg::SUBPIXEL_STEPS));
	assign e_neg = -e_v;
	assign e_pos = !e_v[EVW-1] && (e_v != '0);

	// depth quotient with saturation
	logic [15:0] z_val;
	assign z_val = div_quo[16] ? 16'hFFFF : div_quo[15:0];

	logic [7:0] col_sel [0:2];
	assign col_sel[0] = vcol_q[cnt_q][23:16];
	assign col_sel[1] = vcol_q[cnt_q][15:8];
	assign col_sel[2] = vcol_q[cnt_q][7:0];

	assign item_acc     = item_valid && !item_stall;
	assign out_load     = (state_q == terdt_pkg::ST_DONE) && (!out_valid_q || !result_stall);
	assign cfg_ready    = 1'b1;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// next state and control
	always_comb begin
		state_d          = state_q;
		item_stall       = (state_q != terdt_pkg::ST_IDLE) || clearing;
		mem_rd_en        = 1'b0;
		mem_wr_en        = 1'b0;
		div_req          = '0;
		unique case (state_q)
			terdt_pkg::ST_IDLE: begin
				if (item_valid && !clearing) begin
					if (item.action == terdt_pkg::ACT_PIXEL) begin
						state_d = terdt_pkg::ST_PIXEL;
					end else if (item.vertex_slot == terdt_pkg::SLOT_LAST) begin
						state_d = terdt_pkg::ST_SETUP;
					end else begin
						state_d = terdt_pkg::ST_DONE;
					end
				end
			end
			terdt_pkg::ST_SETUP: begin
				if (cnt_last) begin
					state_d = terdt_pkg::ST_DONE;
				end
			end
			terdt_pkg::ST_PIXEL: begin
				if (!in_range || !tri_valid_q) begin
					state_d = terdt_pkg::ST_DONE;
				end else begin
					mem_rd_en = 1'b1;
					state_d   = terdt_pkg::ST_EDGE;
				end
			end
			terdt_pkg::ST_EDGE: begin
				if (cnt_last) begin
					state_d = (ncov_q || e_pos) ? terdt_pkg::ST_DONE : terdt_pkg::ST_ZMUL;
				end
			end
			terdt_pkg::ST_ZMUL: begin
				if (cnt_last) begin
					state_d = terdt_pkg::ST_ZDIVS;
				end
			end
			terdt_pkg::ST_ZDIVS: begin
				div_req.start      = 1'b1;
				div_req.dividend   = DIVW'(zsum_q) + DIVW'(dn_q >> 1);
				div_req.divisor_sh = DIVW'(dn_q) << (Z_BITS - 1);
				div_req.nbits      = NBW'(Z_BITS);
				state_d            = terdt_pkg::ST_ZDIV;
			end
			terdt_pkg::ST_ZDIV: begin
				if (div_done) begin
					if (z_val > mem_rd_data) begin
						state_d = terdt_pkg::ST_DONE;
					end else begin
						mem_wr_en = 1'b1;
						state_d   = terdt_pkg::ST_LDIVS;
					end
				end
			end
			terdt_pkg::ST_LDIVS: begin
				div_req.start      = 1'b1;
				div_req.dividend   = DIVW'(n_q[cnt_q]) << 16;
				div_req.divisor_sh = DIVW'(dn_q) << (L_BITS - 1);
				div_req.nbits      = NBW'(L_BITS);
				state_d            = terdt_pkg::ST_LDIV;
			end
			terdt_pkg::ST_LDIV: begin
				if (div_done) begin
					state_d = cnt_last ? terdt_pkg::ST_QMUL : terdt_pkg::ST_LDIVS;
				end
			end
			terdt_pkg::ST_QMUL: begin
				state_d = terdt_pkg::ST_CACC;
			end
			terdt_pkg::ST_CACC: begin
				state_d = cnt_last ? terdt_pkg::ST_CDIVS : terdt_pkg::ST_QMUL;
			end
			terdt_pkg::ST_CDIVS: begin
				if (den_q == '0) begin
					state_d = terdt_pkg::ST_DONE;
				end else begin
					div_req.start      = 1'b1;
					div_req.dividend   = DIVW'(num_q[cnt_q]) + DIVW'(den_q >> 1);
					div_req.divisor_sh = DIVW'(den_q) << (C_BITS - 1);
					div_req.nbits      = NBW'(C_BITS);
					state_d            = terdt_pkg::ST_CDIV;
				end
			end
			terdt_pkg::ST_CDIV: begin
				if (div_done) begin
					state_d = cnt_last ? terdt_pkg::ST_DONE : terdt_pkg::ST_CDIVS;
				end
			end
			terdt_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = terdt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = terdt_pkg::ST_IDLE;
			end
		endcase
	end

	// control state, configuration, triangle setup
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= terdt_pkg::ST_IDLE;
			vw_cfg_q    <= 9'd256;
			vh_cfg_q    <= 9'd256;
			tri_valid_q <= 1'b0;
			area_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				ea_q[i] <= '0;
				eb_q[i] <= '0;
				ec_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					terdt_pkg::CFG_WIDTH:  vw_cfg_q <= cfg_data;
					terdt_pkg::CFG_HEIGHT: vh_cfg_q <= cfg_data;
					default:               vw_cfg_q <= vw_cfg_q;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				terdt_pkg::ST_IDLE: begin
					cnt_q <= '0;
					if (item_acc && item.action == terdt_pkg::ACT_VERTEX
					    && item.vertex_slot != terdt_pkg::SLOT_NONE) begin
						tri_valid_q <= 1'b0;
						area_q      <= '0;
					end
				end
				terdt_pkg::ST_SETUP: begin
					ea_q[cnt_q] <= s_a;
					eb_q[cnt_q] <= s_b;
					ec_q[cnt_q] <= s_c;
					area_q      <= area_nx;
					cnt_q       <= cnt_step;
					if (cnt_last) begin
						tri_valid_q <= area_nx[19];
					end
				end
				terdt_pkg::ST_PIXEL: cnt_q <= '0;
				terdt_pkg::ST_EDGE,
				terdt_pkg::ST_ZMUL,
				terdt_pkg::ST_CACC:  cnt_q <= cnt_step;
				terdt_pkg::ST_ZDIV:  cnt_q <= '0;
				terdt_pkg::ST_LDIV,
				terdt_pkg::ST_CDIV: begin
					if (div_done) begin
						cnt_q <= cnt_step;
					end
				end
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// payload and arithmetic registers
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res_q;
		end
		case (state_q)
			terdt_pkg::ST_IDLE: begin
				if (item_acc) begin
					px_q   <= item.pixel_x;
					py_q   <= item.pixel_y;
					res_q  <= '0;
					ncov_q <= 1'b0;
					if (item.action == terdt_pkg::ACT_VERTEX
					    && item.vertex_slot != terdt_pkg::SLOT_NONE) begin
						vx_q[item.vertex_slot]    <= item.vertex_x;
						vy_q[item.vertex_slot]    <= item.vertex_y;
						vz_q[item.vertex_slot]    <= item.vertex_depth;
						vinvw_q[item.vertex_slot] <= item.vertex_inv_w;
						vcol_q[item.vertex_slot]  <= {item.vertex_red, item.vertex_green,
						                              item.vertex_blue};
					end
				end
			end
			terdt_pkg::ST_SETUP: begin
				if (cnt_last) begin
					res_q.triangle_culled <= !area_nx[19];
				end
			end
			terdt_pkg::ST_PIXEL: begin
				res_q.triangle_culled <= !tri_valid_q;
				if (in_range) begin
					res_q.pixel_index <= idx_full[15:0];
				end
				addr_q <= idx_full[AW-1:0];
				dn_q   <= DNW'(area_mag) * DNW'(terdt_pkg::SCALE);
				zsum_q <= '0;
			end
			terdt_pkg::ST_EDGE: begin
				n_q[cnt_q] <= e_neg[DNW-1:0];
				if (e_pos) begin
					ncov_q <= 1'b1;
				end
			end
			terdt_pkg::ST_ZMUL: begin
				zsum_q <= zsum_q + ZSW'(n_q[cnt_q]) * ZSW'(vz_q[cnt_q]);
			end
			terdt_pkg::ST_ZDIV: begin
				if (div_done) begin
					res_q.covered <= 1'b1;
					res_q.depth   <= z_val;
					if (z_val <= mem_rd_data) begin
						res_q.depth_passed <= 1'b1;
					end
					den_q <= '0;
					for (int c = 0; c < 3; c++) begin
						num_q[c] <= '0;
					end
				end
			end
			terdt_pkg::ST_LDIV: begin
				if (div_done) begin
					l_q[cnt_q] <= div_quo;
				end
			end
			terdt_pkg::ST_QMUL: begin
				qp_q <= QW'(l_q[cnt_q]) * QW'(vinvw_q[cnt_q]);
			end
			terdt_pkg::ST_CACC: begin
				den_q <= den_q + DENW'(qp_q);
				for (int c = 0; c < 3; c++) begin
					num_q[c] <= num_q[c] + NUMW'(qp_q) * NUMW'(col_sel[c]);
				end
			end
			terdt_pkg::ST_CDIV: begin
				if (div_done) begin
					case (cnt_q)
						2'd0:    res_q.red   <= div_quo[7:0];
						2'd1:    res_q.green <= div_quo[7:0];
						default: res_q.blue  <= div_quo[7:0];
					endcase
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	terdt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quo    (div_quo)
	);

	terdt_zmem #(
		.ENTRIES (ENTRIES)
	) u_zmem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (mem_rd_en),
		.rd_addr  (idx_full[AW-1:0]),
		.rd_data  (mem_rd_data),
		.wr_en    (mem_wr_en),
		.wr_addr  (addr_q),
		.wr_data  (z_val),
		.clearing (clearing)
	);

endmodule

// File: tb/raster_result_checker.sv
// Result checker for the triangle rasterizer: watches the channels, predicts and compares.
`timescale 1ns / 100ps

module raster_result_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic                item_stall,
	input  terdt_pkg::item_t    item,
	input  logic                result_valid,
	input  logic                result_stall,
	input  terdt_pkg::result_t  result,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [0:0]          cfg_index,
	input  logic [8:0]          cfg_data,
	output int                  mismatches,
	output int                  outstanding
);

	localparam int FB_WIDTH  = 256;
	localparam int FB_HEIGHT = 256;
	localparam int SUBSTEPS  = 16;

	logic [8:0]  view_w, view_h;
	logic [8:0]  corner_x [3];
	logic [8:0]  corner_y [3];
	logic [15:0] corner_z [3];
	logic [31:0] corner_invw [3];
	logic [7:0]  corner_rgb [3][3];
	longint      edge_a [3], edge_b [3], edge_c [3];
	longint      tri_area;
	logic        tri_ok;
	logic [15:0] zbuf [FB_WIDTH*FB_HEIGHT];
	terdt_pkg::result_t pending_results [$];

	assign outstanding = pending_results.size();

	function automatic int unsigned clamp_view(input logic [8:0] v, input int unsigned lim);
		if (v == 0)
			return 1;
		if (v > lim)
			return lim;
		return 32'(v);
	endfunction

	function automatic void triangle_setup();
		longint x [3], y [3];
		int j, k;
		tri_area = 0;
		for (int i = 0; i < 3; i++) begin
			x[i] = corner_x[i];
			y[i] = corner_y[i];
		end
		for (int i = 0; i < 3; i++) begin
			j = (i + 1) % 3;
			k = (i + 2) % 3;
			edge_a[i] = y[j] - y[k];
			edge_b[i] = x[k] - x[j];
			edge_c[i] = x[j] * y[k] - x[k] * y[j];
			tri_area += edge_c[i];
		end
		tri_ok = (tri_area < 0);
	endfunction

	// Work out the result of one item and advance the shadow state.
	function automatic terdt_pkg::result_t rasterize(input terdt_pkg::item_t it);
		terdt_pkg::result_t r;
		int unsigned w, h, px, py, idx;
		longint      ev;
		logic [63:0] wt [3];
		logic [63:0] num [3];
		logic [63:0] dn, zsum, z, den, lam, q, c;
		int          s;
		r = '0;
		if (it.action == terdt_pkg::ACT_VERTEX) begin
			if (it.vertex_slot == terdt_pkg::SLOT_NONE)
				return r;
			s = it.vertex_slot;
			tri_ok = 1'b0;
			corner_x[s]      = it.vertex_x;
			corner_y[s]      = it.vertex_y;
			corner_z[s]      = it.vertex_depth;
			corner_invw[s]   = it.vertex_inv_w;
			corner_rgb[s][0] = it.vertex_red;
			corner_rgb[s][1] = it.vertex_green;
			corner_rgb[s][2] = it.vertex_blue;
			if (it.vertex_slot == terdt_pkg::SLOT_LAST) begin
				triangle_setup();
				r.triangle_culled = !tri_ok;
			end
			return r;
		end
		w  = clamp_view(view_w, FB_WIDTH);
		h  = clamp_view(view_h, FB_HEIGHT);
		px = it.pixel_x;
		py = it.pixel_y;
		r.triangle_culled = !tri_ok;
		if (px >= w || py >= h)
			return r;
		idx = (h - 1 - py) * w + px;
		r.pixel_index = idx[15:0];
		if (!tri_ok)
			return r;
		for (int i = 0; i < 3; i++) begin
			ev = edge_a[i] * longint'(2 * px + 1) + edge_b[i] * longint'(2 * py + 1)
				+ edge_c[i] * 2;
			ev = ev * SUBSTEPS;
			if (ev > 0)
				return r;
			wt[i] = -ev;
		end
		dn = (-tri_area) * 2 * SUBSTEPS;
		if (dn == 0)
			return r;
		r.covered = 1'b1;
		zsum = 0;
		for (int i = 0; i < 3; i++)
			zsum += wt[i] * corner_z[i];
		z = (zsum + dn / 2) / dn;
		if (z > 64'hFFFF)
			z = 64'hFFFF;
		r.depth = z[15:0];
		if (z > zbuf[idx])
			return r;
		zbuf[idx] = z[15:0];
		r.depth_passed = 1'b1;
		den = 0;
		num[0] = 0; num[1] = 0; num[2] = 0;
		for (int i = 0; i < 3; i++) begin
			lam = (wt[i] * 65536) / dn;
			q   = lam * corner_invw[i];
			den += q;
			for (int ch = 0; ch < 3; ch++)
				num[ch] += q * corner_rgb[i][ch];
		end
		for (int ch = 0; ch < 3; ch++) begin
			c = 0;
			if (den != 0)
				c = (num[ch] + den / 2) / den;
			if (c > 255)
				c = 255;
			case (ch)
				0: r.red   = c[7:0];
				1: r.green = c[7:0];
				default: r.blue = c[7:0];
			endcase
		end
		return r;
	endfunction

	task automatic check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		terdt_pkg::result_t want;
		if (!arst_n) begin
			mismatches = 0;
			view_w = 9'd256;
			view_h = 9'd256;
			tri_ok = 1'b0;
			tri_area = 0;
			for (int i = 0; i < 3; i++) begin
				edge_a[i] = 0; edge_b[i] = 0; edge_c[i] = 0;
			end
			for (int i = 0; i < FB_WIDTH * FB_HEIGHT; i++)
				zbuf[i] = '1;
			pending_results.delete();
		end else begin
			// Retire the result first: it always belongs to an earlier transfer.
			if (result_valid && !result_stall) begin
				if (pending_results.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, actual %h", $time, result);
				end else begin
					want = pending_results.pop_front();
					check_field("triangle_culled", want.triangle_culled, result.triangle_culled);
					check_field("covered", want.covered, result.covered);
					check_field("depth_passed", want.depth_passed, result.depth_passed);
					check_field("pixel_index", want.pixel_index, result.pixel_index);
					check_field("depth", want.depth, result.depth);
					check_field("red", want.red, result.red);
					check_field("green", want.green, result.green);
					check_field("blue", want.blue, result.blue);
				end
			end
			if (item_valid && !item_stall)
				pending_results.push_back(rasterize(item));
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == terdt_pkg::CFG_WIDTH)
					view_w = cfg_data;
				else
					view_h = cfg_data;
			end
		end
	end

endmodule

// File: tb/tb_triangle_edge_rasterizer_depth_test.sv
// Testbench top for the triangle rasterizer: stimulus, stalls and the verdict.
`timescale 1ns / 100ps

module tb_triangle_edge_rasterizer_depth_test;

	logic               clk;
	logic               arst_n;
	logic               item_valid;
	logic               item_stall;
	terdt_pkg::item_t   item;
	logic               result_valid;
	logic               result_stall;
	terdt_pkg::result_t result;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [0:0]         cfg_index;
	logic [8:0]         cfg_data;
	int                 mismatches;
	int                 outstanding;

	// Set by the sender and the receiver for stretches of back-to-back transfers.
	logic send_quiet;
	logic recv_quiet;
	int   results_seen;

	triangle_edge_rasterizer_depth_test dut (
		.clk, .arst_n,
		.item_valid, .item_stall, .item,
		.result_valid, .result_stall, .result,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	raster_result_checker checker_i (
		.clk, .arst_n,
		.item_valid, .item_stall, .item,
		.result_valid, .result_stall, .result,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.mismatches, .outstanding
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Give up long after the slowest correct run, clearing sweep included.
	initial begin
		#40_000_000;
		$display("FAILURE");
		$finish;
	end

	// Offer one item, hold it until the transfer, then idle for a drawn gap.
	// Valid is raised only when low, so it never takes two updates in one step.
	task automatic push_item(input terdt_pkg::item_t it);
		logic stalled;
		int   gap;
		item <= it;
		if (!item_valid)
			item_valid <= 1'b1;
		do begin
			@(negedge clk);
			stalled = item_stall;
			@(posedge clk);
		end while (stalled);
		gap = send_quiet ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Write one viewport register; only called with nothing in flight.
	task automatic write_view(input logic [0:0] idx, input logic [8:0] val);
		logic rdy;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do begin
			@(negedge clk);
			rdy = cfg_ready;
			@(posedge clk);
		end while (!rdy);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		if (item_valid) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		wait (outstanding == 0);
		repeat (20) @(posedge clk);
	endtask

	function automatic terdt_pkg::item_t vertex(input logic [1:0] slot, input int x,
			input int y, input logic [15:0] z, input logic [31:0] iw, input logic [23:0] rgb);
		terdt_pkg::item_t v;
		v = '0;
		v.action       = terdt_pkg::ACT_VERTEX;
		v.vertex_slot  = slot;
		v.vertex_x     = 9'(x);
		v.vertex_y     = 9'(y);
		v.vertex_depth = z;
		v.vertex_inv_w = iw;
		{v.vertex_red, v.vertex_green, v.vertex_blue} = rgb;
		return v;
	endfunction

	function automatic terdt_pkg::item_t pixel(input int x, input int y);
		terdt_pkg::item_t p;
		p = '0;
		p.action  = terdt_pkg::ACT_PIXEL;
		p.pixel_x = 8'(x);
		p.pixel_y = 8'(y);
		return p;
	endfunction

	// Doubled signed area as the block sees it; negative means kept.
	function automatic longint doubled_area(input int x [3], input int y [3]);
		longint s;
		s = 0;
		for (int i = 0; i < 3; i++)
			s += longint'(x[(i+1)%3]) * y[(i+2)%3] - longint'(x[(i+2)%3]) * y[(i+1)%3];
		return s;
	endfunction

	// One triangle with random content followed by pixels mostly inside its box.
	task automatic random_triangle(inout int sent);
		int          x [3], y [3];
		int          ox, oy, span, tmp, npix, lox, hix, loy, hiy;
		logic [31:0] iw;
		logic        no_weight;
		span = ($urandom_range(0, 7) == 0) ? 256 : $urandom_range(2, 48);
		ox = $urandom_range(0, 256 - span);
		oy = $urandom_range(0, 256 - span);
		for (int i = 0; i < 3; i++) begin
			x[i] = ox + $urandom_range(0, span);
			y[i] = oy + $urandom_range(0, span);
		end
		if ($urandom_range(0, 19) == 0) begin
			x[2] = x[1];
			y[2] = y[1];
		end
		// Most triangles get the kept winding so that pixels reach the depth path.
		if ($urandom_range(0, 3) != 0 && doubled_area(x, y) > 0) begin
			tmp = x[1]; x[1] = x[2]; x[2] = tmp;
			tmp = y[1]; y[1] = y[2]; y[2] = tmp;
		end
		no_weight = ($urandom_range(0, 19) == 0);
		for (int i = 0; i < 3; i++) begin
			case ($urandom_range(0, 9))
				0:       iw = 32'hFFFF_FFFF;
				1:       iw = $urandom;
				default: iw = $urandom_range(32'h1000, 32'h40000);
			endcase
			if (no_weight)
				iw = '0;
			push_item(vertex(2'(i), x[i], y[i], 16'($urandom), iw, 24'($urandom)));
			sent++;
		end
		lox = x[0]; hix = x[0]; loy = y[0]; hiy = y[0];
		for (int i = 1; i < 3; i++) begin
			lox = (x[i] < lox) ? x[i] : lox; hix = (x[i] > hix) ? x[i] : hix;
			loy = (y[i] < loy) ? y[i] : loy; hiy = (y[i] > hiy) ? y[i] : hiy;
		end
		hix = (hix > 255) ? 255 : hix;
		hiy = (hiy > 255) ? 255 : hiy;
		lox = (lox > hix) ? hix : lox;
		loy = (loy > hiy) ? hiy : loy;
		npix = $urandom_range(1, 12);
		for (int n = 0; n < npix; n++) begin
			if ($urandom_range(0, 4) != 0)
				push_item(pixel($urandom_range(lox, hix), $urandom_range(loy, hiy)));
			else
				push_item(pixel($urandom_range(0, 255), $urandom_range(0, 255)));
			sent++;
			// Noise: a stray load drops the triangle, an empty slot is ignored.
			case ($urandom_range(0, 24))
				0: begin
					push_item(vertex(2'($urandom_range(0, 1)), $urandom_range(0, 256),
						$urandom_range(0, 256), 16'($urandom), $urandom, 24'($urandom)));
					sent++;
				end
				1: push_item(vertex(terdt_pkg::SLOT_NONE, $urandom_range(0, 511),
					$urandom_range(0, 511), 16'($urandom), $urandom, 24'($urandom)));
				default: ;
			endcase
		end
	endtask

	// Receiver: stall a drawn number of cycles per result, once for a long stretch.
	initial begin
		int   hold;
		logic seen;
		result_stall = 1'b0;
		results_seen = 0;
		recv_quiet   = 1'b0;
		@(posedge arst_n);
		forever begin
			if (results_seen % 40 == 0)
				recv_quiet = ($urandom_range(0, 3) == 0);
			hold = recv_quiet ? 0 : $urandom_range(0, 9);
			if (results_seen == 300)
				hold = 800;
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				result_stall <= 1'b0;
			end
			do begin
				@(negedge clk);
				seen = result_valid;
				@(posedge clk);
			end while (!seen);
			results_seen++;
		end
	end

	initial begin
		logic [8:0] widths  [6] = '{9'd256, 9'd1, 9'd0, 9'd511, 9'd173, 9'd64};
		logic [8:0] heights [6] = '{9'd256, 9'd300, 9'd1, 9'd0, 9'd91, 9'd256};
		int sent;
		arst_n     <= 1'b0;
		item_valid <= 1'b0;
		item       <= '0;
		cfg_valid  <= 1'b0;
		cfg_index  <= terdt_pkg::CFG_WIDTH;
		cfg_data   <= '0;
		send_quiet <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: no triangle held yet, so the pixel reports culled.
		push_item(pixel(0, 0));
		// Fill every slot before any setup so no unwritten vertex is read.
		push_item(vertex(0, 0, 0, 16'h0000, 32'hFFFF_FFFF, 24'hFF0000));
		push_item(vertex(1, 10, 0, 16'hFFFF, 32'h0001_0000, 24'h00FF00));
		// Positive area: culled at setup.
		push_item(vertex(2, 0, 10, 16'h8000, 32'h0000_0001, 24'h0000FF));
		push_item(pixel(2, 2));
		// Collinear corners: zero area is culled too.
		push_item(vertex(2, 20, 0, 16'h8000, 32'h0001_0000, 24'h0000FF));
		// Kept triangle spanning the screen, extremes of position, depth and colour.
		push_item(vertex(0, 0, 0, 16'h0000, 32'hFFFF_FFFF, 24'hFFFFFF));
		push_item(vertex(1, 0, 256, 16'hFFFF, 32'h0001_0000, 24'h000000));
		push_item(vertex(2, 256, 0, 16'h4000, 32'h0000_0001, 24'hFF00FF));
		push_item(pixel(0, 0));
		push_item(pixel(0, 0));        // equal depth still passes
		push_item(pixel(255, 255));    // outside the hypotenuse
		push_item(pixel(100, 50));
		push_item(pixel(0, 255));
		push_item(pixel(255, 0));
		// Farthest-depth triangle with no perspective weight: colour drops to zero.
		push_item(vertex(0, 0, 0, 16'hFFFF, 32'h0, 24'h123456));
		push_item(vertex(1, 0, 64, 16'hFFFF, 32'h0, 24'h654321));
		push_item(vertex(2, 64, 0, 16'hFFFF, 32'h0, 24'hABCDEF));
		push_item(pixel(0, 0));        // farther than stored: depth test fails
		push_item(pixel(30, 10));
		// Empty slot is ignored; a slot 0 load drops the triangle.
		push_item(vertex(terdt_pkg::SLOT_NONE, 511, 511, 16'hFFFF, 32'hFFFF_FFFF,
			24'hFFFFFF));
		push_item(vertex(0, 5, 5, 16'h1234, 32'h0002_0000, 24'h808080));
		push_item(pixel(30, 10));

		// Random phases, each under its own viewport setting.
		sent = 0;
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			write_view(terdt_pkg::CFG_WIDTH, widths[ph]);
			write_view(terdt_pkg::CFG_HEIGHT, heights[ph]);
			while (sent < (ph + 1) * 105) begin
				send_quiet <= ($urandom_range(0, 4) == 0);
				random_triangle(sent);
			end
		end

		drain();
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
